// ----- hw/rtl/lcf_pkg.sv -----
// ----------------------------------------------------------------------------
// lcf_pkg: shared types and codes for the lattice constant fold ALU
// Lattice kinds, operation codes and the item record that flows down the
// divider pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package lcf_pkg;

  localparam int DivSteps = 32;

  typedef enum logic [1:0] {
    K_UNKNOWN = 2'd0,
    K_CONST   = 2'd1,
    K_OVER    = 2'd2,
    K_RSVD    = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    OP_NEG    = 5'd0,
    OP_BNOT   = 5'd1,
    OP_NOT    = 5'd2,
    OP_ADD    = 5'd3,
    OP_SUB    = 5'd4,
    OP_MUL    = 5'd5,
    OP_SDIV   = 5'd6,
    OP_UDIV   = 5'd7,
    OP_SREM   = 5'd8,
    OP_UREM   = 5'd9,
    OP_AND    = 5'd10,
    OP_XOR    = 5'd11,
    OP_OR     = 5'd12,
    OP_SHL    = 5'd13,
    OP_SRA    = 5'd14,
    OP_SRL    = 5'd15,
    OP_EQ     = 5'd16,
    OP_NE     = 5'd17,
    OP_SLT    = 5'd18,
    OP_ULT    = 5'd19,
    OP_SGT    = 5'd20,
    OP_UGT    = 5'd21,
    OP_SLE    = 5'd22,
    OP_ULE    = 5'd23,
    OP_SGE    = 5'd24,
    OP_UGE    = 5'd25,
    OP_ICAST  = 5'd26,
    OP_PCAST  = 5'd27,
    OP_JOIN   = 5'd28,
    OP_RSV29  = 5'd29,
    OP_RSV30  = 5'd30,
    OP_RSV31  = 5'd31
  } op_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] bits;
    logic        use_div;
    logic        sel_rem;
    logic        negate;
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] den;
  } lcf_item_t;

  function automatic kind_t norm_kind(input logic [1:0] k);
    norm_kind = (k[1]) ? K_OVER : kind_t'(k);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lcf_front.sv -----
// ----------------------------------------------------------------------------
// lcf_front: decode and folding stage
// Resolves lattice precedence, folds every operation except divide, remainder
// and OP_PCAST (made overdefined), and prepares operand magnitudes for the divider pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module lcf_front import lcf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        v_in,
  input  wire logic [4:0]  cmd,
  input  wire logic [1:0]  lhs_kind,
  input  wire logic [31:0] lhs_bits,
  input  wire logic [1:0]  rhs_kind,
  input  wire logic [31:0] rhs_bits,
  output logic             v_out,
  output lcf_item_t        item_out
);

  op_t         op;
  kind_t       lk;
  kind_t       rk;
  logic [31:0] l;
  logic [31:0] r;
  logic [31:0] mul;
  logic        slt;
  logic        sgt;
  logic        sdiv_bad;
  logic        sh_bad;
  logic [31:0] l_abs;
  logic [31:0] r_abs;
  logic [31:0] fold;
  logic        fault;
  lcf_item_t   item_next;

  assign op  = op_t'(cmd);
  assign lk  = norm_kind(lhs_kind);
  assign rk  = norm_kind(rhs_kind);
  assign l   = lhs_bits;
  assign r   = rhs_bits;
  assign mul = l * r;
  assign slt = $signed(l) < $signed(r);
  assign sgt = $signed(l) > $signed(r);
  assign sdiv_bad = (r == 32'd0) || (l == 32'h8000_0000 && r == 32'hFFFF_FFFF);
  assign sh_bad   = (r > 32'd31);
  assign l_abs = l[31] ? (32'd0 - l) : l;
  assign r_abs = r[31] ? (32'd0 - r) : r;

  always_comb begin
    fold  = 32'd0;
    fault = 1'b0;
    unique case (op)
      OP_ADD:  fold = l + r;
      OP_SUB:  fold = l - r;
      OP_MUL:  fold = mul;
      OP_SDIV, OP_SREM: fault = sdiv_bad;
      OP_UDIV, OP_UREM: fault = (r == 32'd0);
      OP_AND:  fold = l & r;
      OP_XOR:  fold = l ^ r;
      OP_OR:   fold = l | r;
      OP_SHL: begin
        fold  = l << r[4:0];
        fault = sh_bad;
      end
      OP_SRA: begin
        fold  = 32'($signed(l) >>> r[4:0]);
        fault = sh_bad;
      end
      OP_SRL: begin
        fold  = l >> r[4:0];
        fault = sh_bad;
      end
      OP_EQ:  fold = {31'd0, l == r};
      OP_NE:  fold = {31'd0, l != r};
      OP_SLT: fold = {31'd0, slt};
      OP_ULT: fold = {31'd0, l < r};
      OP_SGT: fold = {31'd0, sgt};
      OP_UGT: fold = {31'd0, l > r};
      OP_SLE: fold = {31'd0, !sgt};
      OP_ULE: fold = {31'd0, l <= r};
      OP_SGE: fold = {31'd0, !slt};
      OP_UGE: fold = {31'd0, l >= r};
      default: fold = 32'd0;
    endcase
  end

  always_comb begin
    item_next         = '0;
    item_next.kind    = K_OVER;
    item_next.quo     = (op == OP_SDIV || op == OP_SREM) ? l_abs : l;
    item_next.den     = (op == OP_SDIV || op == OP_SREM) ? r_abs : r;
    item_next.sel_rem = (op == OP_SREM || op == OP_UREM);
    item_next.negate  = (op == OP_SDIV) ? (l[31] ^ r[31]) :
                        (op == OP_SREM) ? l[31] : 1'b0;
    if (cmd <= 5'd2 || op == OP_ICAST) begin
      if (lk == K_OVER) begin
        item_next.kind = K_OVER;
      end else if (lk == K_UNKNOWN) begin
        item_next.kind = K_UNKNOWN;
      end else begin
        item_next.kind = K_CONST;
        item_next.bits = (op == OP_NEG)  ? (32'd0 - l) :
                         (op == OP_BNOT) ? {31'd0, l == 32'd0} :
                         (op == OP_NOT)  ? ~l : l;
      end
    end else if (cmd <= 5'd25) begin
      if (lk == K_OVER || rk == K_OVER) begin
        item_next.kind = K_OVER;
      end else if (lk == K_UNKNOWN || rk == K_UNKNOWN) begin
        item_next.kind = K_UNKNOWN;
      end else if (fault) begin
        item_next.kind = K_OVER;
      end else begin
        item_next.kind    = K_CONST;
        item_next.bits    = fold;
        item_next.use_div = (op == OP_SDIV || op == OP_UDIV ||
                             op == OP_SREM || op == OP_UREM);
      end
    end else if (op == OP_JOIN) begin
      if (lk == K_OVER || rk == K_OVER) begin
        item_next.kind = K_OVER;
      end else if (lk == K_UNKNOWN) begin
        item_next.kind = rk;
        item_next.bits = r;
      end else if (rk == K_UNKNOWN) begin
        item_next.kind = lk;
        item_next.bits = l;
      end else if (l == r) begin
        item_next.kind = K_CONST;
        item_next.bits = l;
      end else begin
        item_next.kind = K_OVER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
    if (en) begin
      item_out <= item_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lcf_div_step.sv -----
// ----------------------------------------------------------------------------
// lcf_div_step: one restoring division step
// Retires one quotient bit per stage; the item record rides along.
// ----------------------------------------------------------------------------
`default_nettype none

module lcf_div_step import lcf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire logic  v_in,
  input  lcf_item_t  item_in,
  output logic       v_out,
  output lcf_item_t  item_out
);

  logic [32:0] shifted;
  logic [32:0] diff;
  logic        take;
  lcf_item_t   item_next;

  assign shifted = {item_in.rem, item_in.quo[31]};
  assign diff    = shifted - {1'b0, item_in.den};
  assign take    = !diff[32];

  always_comb begin
    item_next     = item_in;
    item_next.rem = take ? diff[31:0] : shifted[31:0];
    item_next.quo = {item_in.quo[30:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
    if (en) begin
      item_out <= item_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lattice_constant_fold_alu_unit.sv -----
// ----------------------------------------------------------------------------
// lattice_constant_fold_alu_unit: pipelined lattice constant folder
// Folds one operation over unknown / constant / overdefined operands.
// ----------------------------------------------------------------------------
//  channel | signals                                      | dir
//  --------+----------------------------------------------+-----
//  in      | in_valid, in_ready, cmd, lhs_*, rhs_*        | in
//  out     | out_valid, out_ready, res_kind, res_bits     | out
//
// One item enters per cycle unless the output stalls. Stages: a decode/fold
// stage, 32 divider stages (one quotient bit each), and the output register.
// The decode/fold stage, with its 32x32 multiplier, holds the longest path.
// Every item walks the full pipe.
// Reset clears all valid bits. A stall at the output freezes the whole pipe,
// so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module lattice_constant_fold_alu_unit import lcf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [4:0]  cmd,
  input  wire logic [1:0]  lhs_kind,
  input  wire logic [31:0] lhs_bits,
  input  wire logic [1:0]  rhs_kind,
  input  wire logic [31:0] rhs_bits,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       res_kind,
  output logic [31:0]      res_bits
);

  logic        en;
  logic        v   [DivSteps+1];
  lcf_item_t   itm [DivSteps+1];
  lcf_item_t   last;
  logic [31:0] dres;
  logic [31:0] bits_next;

  // advance whenever the output slot is free or being transferred
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  lcf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .v_in     (in_valid),
    .cmd      (cmd),
    .lhs_kind (lhs_kind),
    .lhs_bits (lhs_bits),
    .rhs_kind (rhs_kind),
    .rhs_bits (rhs_bits),
    .v_out    (v[0]),
    .item_out (itm[0])
  );

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    lcf_div_step u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .v_in     (v[g]),
      .item_in  (itm[g]),
      .v_out    (v[g+1]),
      .item_out (itm[g+1])
    );
  end

  assign last = itm[DivSteps];
  assign dres = last.sel_rem ? last.rem : last.quo;

  always_comb begin
    bits_next = last.bits;
    if (last.use_div) begin
      bits_next = last.negate ? (32'd0 - dres) : dres;
    end
    if (last.kind != K_CONST) begin
      bits_next = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[DivSteps];
    end
    if (en) begin
      res_kind <= last.kind;
      res_bits <= bits_next;
    end
  end

endmodule

`default_nettype wire
